/* rtl/rfab_pkg.sv */
// Package for the rectangle fill alpha blender.
// Holds widths, register index codes and the structs shared by the modules.
// No dependencies.
package rfab_pkg;

  // Pixel coordinate width and the signed compare width that covers it
  localparam int COORD_BITS = 12;
  localparam int BOUND_BITS = 16;
  localparam int CMP_BITS   = BOUND_BITS + 1;

  // Configuration port widths
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  // Register index codes
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECT_LEFT   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECT_TOP    = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECT_RIGHT  = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECT_BOTTOM = 4'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_RED    = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_GREEN  = 4'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_BLUE   = 4'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_ALPHA  = 4'd7;

  // Settings seen by the datapath: bounds plus premultiplied color
  typedef struct packed {
    logic signed [BOUND_BITS-1:0] rect_left;
    logic signed [BOUND_BITS-1:0] rect_top;
    logic signed [BOUND_BITS-1:0] rect_right;
    logic signed [BOUND_BITS-1:0] rect_bottom;
    logic [7:0]                   pm_red;
    logic [7:0]                   pm_green;
    logic [7:0]                   pm_blue;
    logic [7:0]                   inv_alpha;
  } rfab_cfg_t;

  // One incoming pixel
  typedef struct packed {
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic                  in_update_area;
    logic [7:0]            dst_blue;
    logic [7:0]            dst_green;
    logic [7:0]            dst_red;
    logic [7:0]            dst_alpha;
  } rfab_pix_t;

  // One result pixel
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       was_blended;
  } rfab_res_t;

endpackage

/* rtl/rfab_pix_if.sv */
// Pixel input channel: valid/ready handshake with the destination pixel.
// Depends on rfab_pkg for the coordinate width.
interface rfab_pix_if import rfab_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic                  in_update_area;
  logic [7:0]            dst_blue;
  logic [7:0]            dst_green;
  logic [7:0]            dst_red;
  logic [7:0]            dst_alpha;

  modport source (output valid, pix_x, pix_y, in_update_area,
                  output dst_blue, dst_green, dst_red, dst_alpha, input ready);
  modport sink   (input valid, pix_x, pix_y, in_update_area,
                  input dst_blue, dst_green, dst_red, dst_alpha, output ready);
endinterface

/* rtl/rfab_res_if.sv */
// Result channel: valid/ready handshake with the blended pixel.
// No dependencies.
interface rfab_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_alpha;
  logic       was_blended;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, was_blended,
                  input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, was_blended,
                  output ready);
endinterface

/* rtl/rfab_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on rfab_pkg for the port widths.
interface rfab_cfg_if import rfab_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rfab_cfg_regs.sv */
// Configuration registers and the premultiplied fill color.
// Depends on rfab_pkg and rfab_cfg_if.
module rfab_cfg_regs import rfab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rfab_cfg_if.sink   cfg,
  output rfab_cfg_t  settings
);

  logic signed [BOUND_BITS-1:0] rect_left;
  logic signed [BOUND_BITS-1:0] rect_top;
  logic signed [BOUND_BITS-1:0] rect_right;
  logic signed [BOUND_BITS-1:0] rect_bottom;
  logic [7:0] fill_red;
  logic [7:0] fill_green;
  logic [7:0] fill_blue;
  logic [7:0] fill_alpha;
  logic [7:0] pm_red;
  logic [7:0] pm_green;
  logic [7:0] pm_blue;
  logic [7:0] inv_alpha;
  logic       wr;

  // Channel times alpha, divided by 255 with truncation (exact below 65280)
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    p = c * a;
    s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return s[15:8];
  endfunction

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid & cfg.ready;

  // Take a write transaction; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left   <= '0;
      rect_top    <= '0;
      rect_right  <= '1;
      rect_bottom <= '1;
      fill_red    <= '0;
      fill_green  <= '0;
      fill_blue   <= '0;
      fill_alpha  <= '0;
    end else if (wr) begin
      case (cfg.index)
        REG_RECT_LEFT:   rect_left   <= cfg.data[BOUND_BITS-1:0];
        REG_RECT_TOP:    rect_top    <= cfg.data[BOUND_BITS-1:0];
        REG_RECT_RIGHT:  rect_right  <= cfg.data[BOUND_BITS-1:0];
        REG_RECT_BOTTOM: rect_bottom <= cfg.data[BOUND_BITS-1:0];
        REG_FILL_RED:    fill_red    <= cfg.data[7:0];
        REG_FILL_GREEN:  fill_green  <= cfg.data[7:0];
        REG_FILL_BLUE:   fill_blue   <= cfg.data[7:0];
        REG_FILL_ALPHA:  fill_alpha  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Register the derived color terms from the raw value registers, in the cycle after they change
  always_ff @(posedge clk) begin
    if (rst) begin
      pm_red    <= '0;
      pm_green  <= '0;
      pm_blue   <= '0;
      inv_alpha <= '1;
    end else begin
      pm_red    <= premul(fill_red, fill_alpha);
      pm_green  <= premul(fill_green, fill_alpha);
      pm_blue   <= premul(fill_blue, fill_alpha);
      inv_alpha <= ~fill_alpha;
    end
  end

  always_comb begin
    settings.rect_left   = rect_left;
    settings.rect_top    = rect_top;
    settings.rect_right  = rect_right;
    settings.rect_bottom = rect_bottom;
    settings.pm_red      = pm_red;
    settings.pm_green    = pm_green;
    settings.pm_blue     = pm_blue;
    settings.inv_alpha   = inv_alpha;
  end

endmodule

/* rtl/rfab_blend_pipe.sv */
// Two-register blend pipeline: input register, rectangle test and blend,
// result register. Depends on rfab_pkg.
module rfab_blend_pipe import rfab_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rfab_cfg_t settings,
  input  logic      in_valid,
  output logic      in_ready,
  input  rfab_pix_t in_pix,
  output logic      out_valid,
  input  logic      out_ready,
  output rfab_res_t out_res
);

  rfab_pix_t pix;
  logic      pix_valid;
  rfab_res_t res;
  logic      res_valid;
  rfab_res_t res_next;
  logic      pix_adv;
  logic      in_rect;
  logic signed [CMP_BITS-1:0] x_s, y_s, lft, top, rgt, bot;
  logic [15:0] prod_b, prod_g, prod_r, prod_a;
  logic [7:0]  inv_dst_alpha;

  function automatic logic signed [CMP_BITS-1:0] sext_bound(
      input logic [BOUND_BITS-1:0] v);
    return $signed({{(CMP_BITS-BOUND_BITS){v[BOUND_BITS-1]}}, v});
  endfunction

  // Stage handshakes: the input register moves on when the result slot frees
  assign pix_adv  = ~res_valid | out_ready;
  assign in_ready = ~pix_valid | pix_adv;

  // Hold the accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (in_ready) begin
      pix_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready & in_valid) begin
      pix <= in_pix;
    end
  end

  // Rectangle test, signed against inclusive bounds
  always_comb begin
    x_s     = $signed({{(CMP_BITS-COORD_BITS){1'b0}}, pix.pix_x});
    y_s     = $signed({{(CMP_BITS-COORD_BITS){1'b0}}, pix.pix_y});
    lft     = sext_bound(settings.rect_left);
    top     = sext_bound(settings.rect_top);
    rgt     = sext_bound(settings.rect_right);
    bot     = sext_bound(settings.rect_bottom);
    in_rect = (x_s >= lft) && (x_s <= rgt) && (y_s >= top) && (y_s <= bot);
  end

  // Blend inside update area and rectangle: scaled destination plus premultiplied fill, 8-bit wrap; else pass through
  always_comb begin
    inv_dst_alpha = ~pix.dst_alpha;
    prod_b = pix.dst_blue  * settings.inv_alpha;
    prod_g = pix.dst_green * settings.inv_alpha;
    prod_r = pix.dst_red   * settings.inv_alpha;
    prod_a = inv_dst_alpha * settings.inv_alpha;
    if (pix.in_update_area && in_rect) begin
      res_next.out_blue    = prod_b[15:8] + settings.pm_blue;
      res_next.out_green   = prod_g[15:8] + settings.pm_green;
      res_next.out_red     = prod_r[15:8] + settings.pm_red;
      res_next.out_alpha   = ~prod_a[15:8];
      res_next.was_blended = 1'b1;
    end else begin
      res_next.out_blue    = pix.dst_blue;
      res_next.out_green   = pix.dst_green;
      res_next.out_red     = pix.dst_red;
      res_next.out_alpha   = pix.dst_alpha;
      res_next.was_blended = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pix_adv) begin
      res_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_adv & pix_valid) begin
      res <= res_next;
    end
  end

  assign out_valid = res_valid;
  assign out_res   = res;

endmodule

/* rtl/rect_fill_alpha_blend.sv */
// Top level of the rectangle fill alpha blender.
// Depends on rfab_pkg, the channel interfaces, rfab_cfg_regs and rfab_blend_pipe.
//
//   channel  interface    role    carries
//   pix      rfab_pix_if  sink    pixel coordinates, update flag, BGRA bytes
//   res      rfab_res_if  source  blended BGRA bytes, blend flag
//   cfg      rfab_cfg_if  sink    register index and write data
//
// One pixel per clock sustained while res is ready; each transaction passes
// through the input register and then the result register.
// The cfg channel is always ready; a write lands in the raw value registers and
// then in the derived color term registers. rst is synchronous and empties both pipeline registers.
// A stalled result holds; pix stays ready while the input register can move
// or is empty.
module rect_fill_alpha_blend import rfab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rfab_pix_if.sink   pix,
  rfab_res_if.source res,
  rfab_cfg_if.sink   cfg
);

  rfab_cfg_t settings;
  rfab_pix_t in_pix;
  rfab_res_t out_res;

  always_comb begin
    in_pix.pix_x          = pix.pix_x;
    in_pix.pix_y          = pix.pix_y;
    in_pix.in_update_area = pix.in_update_area;
    in_pix.dst_blue       = pix.dst_blue;
    in_pix.dst_green      = pix.dst_green;
    in_pix.dst_red        = pix.dst_red;
    in_pix.dst_alpha      = pix.dst_alpha;
  end

  rfab_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  rfab_blend_pipe u_blend_pipe (
    .clk       (clk),
    .rst       (rst),
    .settings  (settings),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .in_pix    (in_pix),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.out_blue    = out_res.out_blue;
  assign res.out_green   = out_res.out_green;
  assign res.out_red     = out_res.out_red;
  assign res.out_alpha   = out_res.out_alpha;
  assign res.was_blended = out_res.was_blended;

endmodule

/* rtl/rfab_checker.sv */
// Port-level checks for the rectangle fill alpha blender, bound to the top.
// No dependencies beyond the top level's ports.
module rfab_checker (
  input logic       clk,
  input logic       rst,
  input logic       pix_valid,
  input logic       pix_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_blue,
  input logic [7:0] res_green,
  input logic [7:0] res_red,
  input logic [7:0] res_alpha,
  input logic       res_blended,
  input logic       cfg_ready
);

  // Reset empties the result slot
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Input backpressure only when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> res_valid)
    else $error("pixel channel stalled with no pending result");

  // An accepted pixel passes the input register and reaches the result register if the sink drains
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) ##1 res_ready |=> res_valid)
    else $error("accepted pixel did not reach the result register");

  // A stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(res_blue) &&
      $stable(res_green) && $stable(res_red) && $stable(res_alpha) &&
      $stable(res_blended))
    else $error("stalled result changed");

  // Configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind rect_fill_alpha_blend rfab_checker u_rfab_checker (
  .clk         (clk),
  .rst         (rst),
  .pix_valid   (pix.valid),
  .pix_ready   (pix.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_blue    (res.out_blue),
  .res_green   (res.out_green),
  .res_red     (res.out_red),
  .res_alpha   (res.out_alpha),
  .res_blended (res.was_blended),
  .cfg_ready   (cfg.ready)
);
